// File: src/dlts_pkg.sv
package dlts_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int RES_LIMIT     = 16;
  localparam logic [7:0] TICK_MS_RST = 8'd10;
  localparam int DIV_W = 32;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [31:0] delta;
    logic [31:0] period;
    logic [7:0]  run;
  } entry_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_TAKE_NEXT,
    CELL_TAKE_NEXT_ADD,
    CELL_TAKE_PREV,
    CELL_TAKE_PREV_SUB,
    CELL_LOAD,
    CELL_TICK,
    CELL_RUN_DEC
  } cell_cmd_e;

  typedef enum logic [1:0] {
    MODE_ADD,
    MODE_DEL,
    MODE_TICK,
    MODE_DISP
  } mode_e;

  typedef enum logic [2:0] {
    RES_RAN      = 3'd0,
    RES_ADDED    = 3'd1,
    RES_DELETED  = 3'd2,
    RES_NOTFOUND = 3'd3,
    RES_FULL     = 3'd4,
    RES_NOTHING  = 3'd5
  } res_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_DIV_D,
    ST_DIV_P,
    ST_INS_START,
    ST_INS_WALK,
    ST_TICK,
    ST_DISP_CHK,
    ST_DISP_REQ,
    ST_DISP_NEXT,
    ST_DISP_CONT,
    ST_EMIT
  } state_e;

endpackage

// File: src/delta_list_task_scheduler_core.sv
// Delta-list timer queue.
// Requests enter on the s_ channel: tuser carries the mode (add, delete,
// tick, dispatch), tdata the task id, delay and period in milliseconds.
// Results leave on the m_ channel: tdata the task id, tuser the event code,
// tlast marks the final result of a request. Dispatch may give up to 16
// results; every other request gives exactly one.
// The queue lives in a row of MAX_TASKS cells; entries shift one place per
// cycle along the row on insert and removal. A request is taken only when
// the controller is idle, one at a time.
// Tick and delete pass through ST_TICK or ST_FIND and then ST_EMIT, which
// loads the result register and returns the controller to idle.
// A new add runs two serial 32-bit divisions by the tick length, then
// walks the list one entry a cycle to its place. Each dispatch run removes
// the head and, if its period is nonzero, queues it again by that period.
// The tick length register is written on the cfg channel; write it only
// while idle. Reset empties the queue and sets the tick length to 10 ms.
// A stalled receiver holds the result register; the controller waits on
// it before loading the next result, though an idle controller may still
// take a new request meanwhile.
module delta_list_task_scheduler_core #(
  parameter int MAX_TASKS = dlts_pkg::MAX_TASKS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [71:0] s_tdata_i,  // task_id[7:0], delay_ms[39:8], period_ms[71:40]
  input  logic [1:0]  s_tuser_i,  // mode[1:0]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [7:0]  m_tdata_o,  // task_id_out[7:0]
  output logic [2:0]  m_tuser_o,  // event_res[2:0]
  output logic        m_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);
  import dlts_pkg::*;

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int NW = $clog2(RES_LIMIT + 1);

  state_e      state_q, state_d, after_q, after_d;
  mode_e       mode_q;
  logic [7:0]  id_q;
  logic [31:0] dms_q, pms_q;
  logic [7:0]  tick_q;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [31:0] base_q, base_d, total_q, total_d;
  entry_t      ins_q, ins_d;
  logic        ins_disp_q, ins_disp_d;
  logic [7:0]  pend_q, pend_d;
  logic [NW-1:0] n_q, n_d;
  logic [7:0]  res_id_q, res_id_d;
  res_e        res_code_q, res_code_d;
  logic        res_last_q, res_last_d;
  logic        out_valid_q;
  logic [7:0]  out_id_q;
  res_e        out_code_q;
  logic        out_last_q;
  logic        out_load;

  entry_t      cells [MAX_TASKS];
  cell_cmd_e   cmds  [MAX_TASKS];
  entry_t      new_entry;
  logic [31:0] sub_val;
  logic [IW-1:0] rd_addr;
  entry_t      rd_entry;

  logic          do_remove, do_place, sub_en, do_tick, do_rundec;
  logic [CW-1:0] rem_pos, place_pos;

  logic          m_found;
  logic [IW-1:0] m_pos;

  logic        div_start, div_done;
  logic [31:0] div_dividend, div_q;
  logic [7:0]  tick_eff;
  logic [CW-1:0] nxt;

  assign tick_eff = (tick_q == '0) ? 8'd1 : tick_q;
  assign rd_entry = cells[rd_addr];
  assign nxt      = CW'(idx_q) + 1'b1;

  // first live entry with a matching id
  always_comb begin
    m_found = 1'b0;
    m_pos   = '0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (CW'(i) < count_q && cells[i].task_id == id_q) begin
        m_found = 1'b1;
        m_pos   = IW'(i);
      end
    end
  end

  dlts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (tick_eff),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // controller
  always_comb begin
    state_d    = state_q;
    after_d    = after_q;
    count_d    = count_q;
    idx_d      = idx_q;
    base_d     = base_q;
    total_d    = total_q;
    ins_d      = ins_q;
    ins_disp_d = ins_disp_q;
    pend_d     = pend_q;
    n_d        = n_q;
    res_id_d   = res_id_q;
    res_code_d = res_code_q;
    res_last_d = res_last_q;
    do_remove  = 1'b0;
    do_place   = 1'b0;
    sub_en     = 1'b0;
    do_tick    = 1'b0;
    do_rundec  = 1'b0;
    rem_pos    = '0;
    place_pos  = '0;
    new_entry  = ins_q;
    sub_val    = '0;
    rd_addr    = '0;
    div_start  = 1'b0;
    div_dividend = dms_q;
    out_load   = 1'b0;
    s_tready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          unique case (mode_e'(s_tuser_i))
            MODE_ADD, MODE_DEL: state_d = ST_FIND;
            MODE_TICK:          state_d = ST_TICK;
            default:            state_d = ST_DISP_CHK;
          endcase
        end
      end
      ST_FIND: begin
        rd_addr    = m_pos;
        res_id_d   = id_q;
        res_last_d = 1'b1;
        after_d    = ST_IDLE;
        if (m_found) begin
          // unlink the entry; its delta moves onto its successor
          do_remove = 1'b1;
          rem_pos   = CW'(m_pos);
          count_d   = count_q - 1'b1;
          if (mode_q == MODE_DEL) begin
            res_code_d = RES_DELETED;
            state_d    = ST_EMIT;
          end else begin
            ins_d.task_id = id_q;
            ins_d.delta   = rd_entry.period;
            ins_d.period  = rd_entry.period;
            ins_d.run     = rd_entry.run;
            ins_disp_d    = 1'b0;
            state_d       = ST_INS_START;
          end
        end else if (mode_q == MODE_DEL) begin
          res_code_d = RES_NOTFOUND;
          state_d    = ST_EMIT;
        end else if (count_q == CW'(MAX_TASKS)) begin
          res_code_d = RES_FULL;
          state_d    = ST_EMIT;
        end else begin
          div_start  = 1'b1;
          ins_d.task_id = id_q;
          ins_d.run  = '0;
          ins_disp_d = 1'b0;
          state_d    = ST_DIV_D;
        end
      end
      ST_DIV_D: begin
        if (div_done) begin
          ins_d.delta  = div_q;
          div_start    = 1'b1;
          div_dividend = pms_q;
          state_d      = ST_DIV_P;
        end
      end
      ST_DIV_P: begin
        if (div_done) begin
          ins_d.period = div_q;
          state_d      = ST_INS_START;
        end
      end
      ST_INS_START: begin
        rd_addr = '0;
        if (count_q == '0) begin
          do_place  = 1'b1;
          place_pos = '0;
          count_d   = count_q + 1'b1;
          state_d   = ins_disp_q ? ST_DISP_NEXT : ST_EMIT;
          res_id_d   = ins_q.task_id;
          res_code_d = RES_ADDED;
          res_last_d = 1'b1;
          after_d    = ST_IDLE;
        end else begin
          idx_d   = '0;
          base_d  = '0;
          total_d = rd_entry.delta;
          state_d = ST_INS_WALK;
        end
      end
      ST_INS_WALK: begin
        rd_addr = IW'(nxt);
        if (total_q <= ins_q.delta && nxt < count_q) begin
          // advance one entry
          idx_d   = IW'(nxt);
          base_d  = total_q;
          total_d = total_q + rd_entry.delta;
        end else begin
          do_place = 1'b1;
          count_d  = count_q + 1'b1;
          if (nxt == count_q && total_q <= ins_q.delta) begin
            place_pos       = count_q;
            new_entry.delta = ins_q.delta - total_q;
          end else begin
            place_pos       = CW'(idx_q);
            new_entry.delta = ins_q.delta - base_q;
            sub_en          = 1'b1;
            sub_val         = ins_q.delta - base_q;
          end
          state_d    = ins_disp_q ? ST_DISP_NEXT : ST_EMIT;
          res_id_d   = ins_q.task_id;
          res_code_d = RES_ADDED;
          res_last_d = 1'b1;
          after_d    = ST_IDLE;
        end
      end
      ST_TICK: begin
        do_tick    = count_q != '0;
        res_id_d   = '0;
        res_code_d = RES_NOTHING;
        res_last_d = 1'b1;
        after_d    = ST_IDLE;
        state_d    = ST_EMIT;
      end
      ST_DISP_CHK: begin
        if (count_q != '0 && cells[0].run != '0) begin
          pend_d    = cells[0].task_id;
          n_d       = NW'(1);
          do_rundec = 1'b1;
          state_d   = ST_DISP_REQ;
        end else begin
          res_id_d   = '0;
          res_code_d = RES_NOTHING;
          res_last_d = 1'b1;
          after_d    = ST_IDLE;
          state_d    = ST_EMIT;
        end
      end
      ST_DISP_REQ: begin
        // take the head off and, if its period is nonzero, queue it again by its period
        ins_d.task_id = cells[0].task_id;
        ins_d.delta   = cells[0].period;
        ins_d.period  = cells[0].period;
        ins_d.run     = cells[0].run;
        ins_disp_d    = 1'b1;
        do_remove     = 1'b1;
        rem_pos       = '0;
        count_d       = count_q - 1'b1;
        state_d       = (cells[0].period != '0) ? ST_INS_START : ST_DISP_NEXT;
      end
      ST_DISP_NEXT: begin
        res_id_d   = pend_q;
        res_code_d = RES_RAN;
        if (count_q != '0 && cells[0].delta == '0 && n_q < NW'(RES_LIMIT)) begin
          res_last_d = 1'b0;
          after_d    = ST_DISP_CONT;
        end else begin
          res_last_d = 1'b1;
          after_d    = ST_IDLE;
        end
        state_d = ST_EMIT;
      end
      ST_DISP_CONT: begin
        pend_d  = cells[0].task_id;
        n_d     = n_q + 1'b1;
        state_d = ST_DISP_REQ;
      end
      ST_EMIT: begin
        if (!out_valid_q || m_tready_i) begin
          out_load = 1'b1;
          state_d  = after_q;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // per-cell commands
  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      cmds[i] = CELL_HOLD;
      if (do_remove) begin
        if (CW'(i) >= rem_pos && CW'(i) + 1'b1 < count_q)
          cmds[i] = (CW'(i) == rem_pos) ? CELL_TAKE_NEXT_ADD : CELL_TAKE_NEXT;
      end else if (do_place) begin
        if (CW'(i) == place_pos)
          cmds[i] = CELL_LOAD;
        else if (sub_en && CW'(i) == place_pos + 1'b1)
          cmds[i] = CELL_TAKE_PREV_SUB;
        else if (CW'(i) > place_pos && CW'(i) <= count_q)
          cmds[i] = CELL_TAKE_PREV;
      end else if (i == 0 && do_tick) begin
        cmds[i] = CELL_TICK;
      end else if (i == 0 && do_rundec) begin
        cmds[i] = CELL_RUN_DEC;
      end
    end
  end

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    dlts_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmds[g]),
      .prev_i  ((g == 0) ? entry_t'('0) : cells[(g == 0) ? 0 : g - 1]),
      .next_i  ((g == MAX_TASKS - 1) ? entry_t'('0) : cells[(g == MAX_TASKS - 1) ? g : g + 1]),
      .new_i   (new_entry),
      .sub_i   (sub_val),
      .entry_o (cells[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      after_q     <= ST_IDLE;
      count_q     <= '0;
      tick_q      <= TICK_MS_RST;
      out_valid_q <= 1'b0;
      ins_disp_q  <= 1'b0;
      n_q         <= '0;
    end else begin
      state_q    <= state_d;
      after_q    <= after_d;
      count_q    <= count_d;
      ins_disp_q <= ins_disp_d;
      n_q        <= n_d;
      if (cfg_valid_i) tick_q <= cfg_data_i;
      if (out_load) out_valid_q <= 1'b1;
      else if (m_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    base_q     <= base_d;
    total_q    <= total_d;
    ins_q      <= ins_d;
    pend_q     <= pend_d;
    res_id_q   <= res_id_d;
    res_code_q <= res_code_d;
    res_last_q <= res_last_d;
    if (s_tvalid_i && s_tready_o) begin
      mode_q <= mode_e'(s_tuser_i);
      id_q   <= s_tdata_i[7:0];
      dms_q  <= s_tdata_i[39:8];
      pms_q  <= s_tdata_i[71:40];
    end
    if (out_load) begin
      out_id_q   <= res_id_q;
      out_code_q <= res_code_q;
      out_last_q <= res_last_q;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign m_tvalid_o  = out_valid_q;
  assign m_tdata_o   = out_id_q;
  assign m_tuser_o   = out_code_q;
  assign m_tlast_o   = out_last_q;

endmodule

// File: src/dlts_div.sv
module dlts_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [dlts_pkg::DIV_W-1:0] dividend_i,
  input  logic [7:0]                divisor_i,
  output logic                      done_o,
  output logic [dlts_pkg::DIV_W-1:0] quotient_o
);
  import dlts_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] quo_q;
  logic [7:0]       rem_q;
  logic [8:0]       trial;
  logic             fits;

  // one quotient bit a cycle, restoring
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? 8'(trial - {1'b0, divisor_i}) : trial[7:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: src/dlts_cell.sv
module dlts_cell (
  input  logic                clk_i,
  input  dlts_pkg::cell_cmd_e cmd_i,
  input  dlts_pkg::entry_t    prev_i,
  input  dlts_pkg::entry_t    next_i,
  input  dlts_pkg::entry_t    new_i,
  input  logic [31:0]         sub_i,
  output dlts_pkg::entry_t    entry_o
);
  import dlts_pkg::*;

  entry_t      entry_q, entry_d;
  logic [31:0] dec;

  assign dec = (entry_q.delta != '0) ? entry_q.delta - 32'd1 : '0;

  always_comb begin
    entry_d = entry_q;
    case (cmd_i)
      CELL_TAKE_NEXT:     entry_d = next_i;
      CELL_TAKE_NEXT_ADD: begin
        entry_d       = next_i;
        entry_d.delta = next_i.delta + entry_q.delta;
      end
      CELL_TAKE_PREV:     entry_d = prev_i;
      CELL_TAKE_PREV_SUB: begin
        entry_d       = prev_i;
        entry_d.delta = prev_i.delta - sub_i;
      end
      CELL_LOAD:          entry_d = new_i;
      CELL_TICK: begin
        entry_d.delta = dec;
        if (dec == '0 && entry_q.run != 8'hFF) entry_d.run = entry_q.run + 8'd1;
      end
      CELL_RUN_DEC:       entry_d.run = entry_q.run - 8'd1;
      default:            entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: src/dlts_checker.sv
module dlts_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_tvalid_o,
  input logic       m_tready_i,
  input logic [7:0] m_tdata_o,
  input logic [2:0] m_tuser_o,
  input logic       m_tlast_o
);
  import dlts_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o)
      && $stable(m_tuser_o) && $stable(m_tlast_o))
    else $error("result changed while stalled");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> m_tuser_o <= RES_NOTHING)
    else $error("bad event code");

  a_nothing_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o == RES_NOTHING |-> m_tdata_o == '0)
    else $error("nothing-done result carries a task id");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o != RES_RAN |-> m_tlast_o)
    else $error("non-dispatch result not marked last");

endmodule

bind delta_list_task_scheduler_core dlts_checker u_dlts_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tuser_o  (m_tuser_o),
  .m_tlast_o  (m_tlast_o)
);
